[hdl/i2cms_pkg.sv]
// Shared types and constants for the I2C master bit sequencer.
package i2cms_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int SEG_W         = $clog2(2 * BITS_PER_BYTE);
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ACT_TICK  = 3'd0,
    ACT_START = 3'd1,
    ACT_STOP  = 3'd2,
    ACT_WRITE = 3'd3,
    ACT_READ  = 3'd4,
    ACT_ACK   = 3'd5,
    ACT_NACK  = 3'd6,
    ACT_WAIT  = 3'd7
  } action_t;

  // One classified beat as it waits in the front queue.
  typedef struct packed {
    logic                     is_cmd;
    action_t                  action;
    logic [BITS_PER_BYTE-1:0] write_data;
    logic                     sda_line;
  } item_t;

  // Sequencer state seen by the top level.
  typedef struct packed {
    logic             busy;
    logic [SEG_W-1:0] seg;
    action_t          cmd;
  } back_status_t;

endpackage

[hdl/i2cms_front.sv]
// Front end: accept input beats, classify them and buffer them in a short queue.
module i2cms_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,
  input  logic [2:0]            in_tuser,
  output logic                  q_valid,
  input  logic                  q_ready,
  output i2cms_pkg::item_t      q_item
);

  i2cms_pkg::item_t                  mem_r [i2cms_pkg::QUEUE_DEPTH];
  logic [i2cms_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [i2cms_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [i2cms_pkg::QCNT_W-1:0]      count_r, count_nxt;
  logic                              push, pop;
  i2cms_pkg::item_t                  item_in;

  // Classify: anything other than a tick is a bus command.
  always_comb begin
    item_in.action     = i2cms_pkg::action_t'(in_tuser);
    item_in.is_cmd     = (item_in.action != i2cms_pkg::ACT_TICK);
    item_in.write_data = in_tdata[i2cms_pkg::BITS_PER_BYTE-1:0];
    item_in.sda_line   = in_tdata[i2cms_pkg::BITS_PER_BYTE];
  end

  assign in_tready = (count_r != i2cms_pkg::QCNT_W'(i2cms_pkg::QUEUE_DEPTH));
  assign q_valid   = (count_r != '0);
  assign q_item    = mem_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == i2cms_pkg::QPTR_W'(i2cms_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == i2cms_pkg::QPTR_W'(i2cms_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

[hdl/i2cms_back.sv]
// Back end: bus segment sequencer and registered result beat.
module i2cms_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  output logic                     q_ready,
  input  i2cms_pkg::item_t         q_item,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [15:0]              out_tdata,
  output i2cms_pkg::back_status_t  status
);

  localparam int BW = i2cms_pkg::BITS_PER_BYTE;
  localparam int SW = i2cms_pkg::SEG_W;

  i2cms_pkg::action_t  cmd_r, cmd_nxt;
  logic [SW-1:0]       seg_r, seg_nxt;
  logic [BW-1:0]       shift_r, shift_nxt;
  logic                busy_r, busy_nxt;
  logic                ack_r, ack_nxt;
  logic                scl_r, scl_nxt;
  logic                sda_r, sda_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [15:0]         out_data_r, out_data_nxt;
  logic                done, rej;
  logic [BW-1:0]       rbyte;
  logic [SW-1:0]       seg_last, seg_inc;
  logic [1:0]          lv;

  // Line levels {scl, sda} for a command's segment.
  function automatic logic [1:0] seg_levels(i2cms_pkg::action_t cmd, logic [SW-1:0] seg,
                                            logic [BW-1:0] shreg);
    logic [SW-2:0] bidx;
    logic [1:0]    r;
    bidx = seg[SW-1:1];
    r    = 2'b11;
    unique case (cmd)
      i2cms_pkg::ACT_START: r = {1'b1, (seg == '0)};
      i2cms_pkg::ACT_STOP:  r = {(seg != '0), (seg == SW'(2))};
      i2cms_pkg::ACT_ACK:   r = {(seg == SW'(1)), 1'b0};
      i2cms_pkg::ACT_NACK,
      i2cms_pkg::ACT_WAIT:  r = {(seg == SW'(1)), 1'b1};
      i2cms_pkg::ACT_WRITE: r = {seg[0], shreg[(SW-1)'(BW - 1) - bidx]};
      i2cms_pkg::ACT_READ:  r = {seg[0], 1'b1};
      default:              r = 2'b11;
    endcase
    return r;
  endfunction

  assign q_ready = !out_valid_r || out_tready;

  always_comb begin
    unique case (cmd_r)
      i2cms_pkg::ACT_START:                      seg_last = SW'(1);
      i2cms_pkg::ACT_WRITE, i2cms_pkg::ACT_READ: seg_last = SW'(2 * BW - 1);
      default:                                   seg_last = SW'(2);
    endcase
  end

  assign seg_inc = seg_r + 1'b1;

  always_comb begin
    cmd_nxt   = cmd_r;
    seg_nxt   = seg_r;
    shift_nxt = shift_r;
    busy_nxt  = busy_r;
    ack_nxt   = ack_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    done      = 1'b0;
    rej       = 1'b0;
    rbyte     = '0;
    lv        = 2'b11;
    if (busy_r) begin
      if (q_item.is_cmd) begin
        rej = 1'b1;
      end else begin
        if (cmd_r == i2cms_pkg::ACT_READ && seg_r[0]) begin
          shift_nxt = {shift_r[BW-2:0], q_item.sda_line};
        end
        if (cmd_r == i2cms_pkg::ACT_WAIT && seg_r == SW'(1)) begin
          ack_nxt = q_item.sda_line;
        end
        if (seg_r == seg_last) begin
          done     = 1'b1;
          busy_nxt = 1'b0;
          seg_nxt  = '0;
          cmd_nxt  = i2cms_pkg::ACT_TICK;
          if (cmd_r == i2cms_pkg::ACT_READ) begin
            rbyte = shift_nxt;
          end
        end else begin
          seg_nxt = seg_inc;
          lv      = seg_levels(cmd_r, seg_inc, shift_r);
          scl_nxt = lv[1];
          sda_nxt = lv[0];
        end
      end
    end else if (q_item.is_cmd) begin
      cmd_nxt  = q_item.action;
      seg_nxt  = '0;
      busy_nxt = 1'b1;
      if (q_item.action == i2cms_pkg::ACT_WRITE) begin
        shift_nxt = q_item.write_data;
      end else if (q_item.action == i2cms_pkg::ACT_READ) begin
        shift_nxt = '0;
      end
      lv      = seg_levels(q_item.action, '0, shift_nxt);
      scl_nxt = lv[1];
      sda_nxt = lv[0];
    end
    out_data_nxt = {2'b00, rej, ack_nxt, rbyte, done, busy_nxt, sda_nxt, scl_nxt};
    out_valid_nxt = (q_valid && q_ready) ? 1'b1 : (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r       <= i2cms_pkg::ACT_TICK;
      seg_r       <= '0;
      shift_r     <= '0;
      busy_r      <= 1'b0;
      ack_r       <= 1'b1;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_valid && q_ready) begin
        cmd_r   <= cmd_nxt;
        seg_r   <= seg_nxt;
        shift_r <= shift_nxt;
        busy_r  <= busy_nxt;
        ack_r   <= ack_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid  = out_valid_r;
  assign out_tdata   = out_data_r;
  assign status.busy = busy_r;
  assign status.seg  = seg_r;
  assign status.cmd  = cmd_r;

endmodule

[hdl/i2c_master_bit_sequencer_unit.sv]
// Top level of the I2C master bit sequencer: front queue, back sequencer, checks.
//
// Usage:
//   Input beats carry a kind in in_tuser (tick or one of the bus commands)
//   plus the write byte and the sampled SDA level in in_tdata. While idle
//   the sequencer takes one command; each later tick beat ends the current
//   hold segment and starts the next. Every input beat yields exactly one
//   result beat with the SCL level, the SDA drive (1 = released), busy and
//   done flags, the read byte (on the done beat of a read only), the last
//   sampled acknowledge and a rejected flag for commands sent while busy.
//   A beat accepted by the front queue is held there and is then registered
//   into the result register once that register is free, from where it
//   appears on out_*.
//   Throughput: one beat per cycle; the sequencer retires one queue entry
//   per cycle whenever the result register is empty or being drained.
//   Bus timing is set entirely by the spacing of tick beats.
//   Reset (rst_n low, synchronous): queue empty, SCL and SDA high, idle,
//   acknowledge reads as nack. When out_tready stays low the result beat
//   holds, the sequencer pauses, and in_tready drops once the queue fills.
module i2c_master_bit_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] write_data, [8] sda_line, [15:9] zero
  input  logic [2:0]  in_tuser,   // [2:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res,
                                  // [11:4] read_byte, [12] ack_sampled, [13] rejected,
                                  // [15:14] zero
);

  logic                     q_valid;
  logic                     q_ready;
  i2cms_pkg::item_t         q_item;
  i2cms_pkg::back_status_t  status;

  // Accept and classify beats, buffer them ahead of the sequencer.
  i2cms_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  // Advance the bus segments and register one result beat per entry.
  i2cms_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .status     (status)
  );

  // Idle sequencer sits at segment zero with no command latched.
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !status.busy |-> (status.seg == '0) && (status.cmd == i2cms_pkg::ACT_TICK))
    else $error("idle sequencer holds stale segment or command");

  // A done beat always reports the sequencer as no longer busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> !out_tdata[2])
    else $error("done beat reports busy");

  // The read byte is zero except on a done beat.
  a_rbyte_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[3] |-> (out_tdata[11:4] == 8'h00))
    else $error("read byte nonzero outside a done beat");

  // A command entering the sequencer while busy leaves the segment untouched.
  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && q_ready && q_item.is_cmd && status.busy |=> $stable(status.seg))
    else $error("rejected command disturbed the segment counter");

endmodule
